### hw/rtl/cpd_pkg.sv
// Package with the item types, status codes and command table of the packet deframer.
`default_nettype none
package cpd_pkg;

	localparam int unsigned NUM_WORDS = 7;
	localparam int unsigned NUM_KNOWN = 16;

	typedef enum logic [1:0] {
		STATUS_OK       = 2'd0,
		STATUS_CHECKSUM = 2'd1,
		STATUS_OVERRUN  = 2'd2
	} status_t;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       overrun;
	} in_item_t;

	typedef struct packed {
		status_t            status;
		logic [15:0]        header_word;
		logic [15:0]        command_code;
		logic [4:0]         action_index;
		logic signed [15:0] first_argument;
		logic [31:0]        second_argument_bits;
		logic [31:0]        third_argument_bits;
	} out_item_t;

	// One classified packet as handed from the front end to the back end.
	typedef struct packed {
		status_t                       status;
		logic [NUM_WORDS-1:0][15:0]    words;
	} frame_rec_t;

	localparam logic [15:0] KNOWN_CODES [NUM_KNOWN] = '{
		16'h0050, 16'h0060, 16'h0061, 16'h0070, 16'h0071, 16'h0072, 16'h0073, 16'h0074,
		16'h0075, 16'h0078, 16'h007A, 16'h007B, 16'h0080, 16'h0090, 16'h0091, 16'h0092
	};

	// Returns the position of the code in the table plus one, or zero when unknown.
	function automatic logic [4:0] lookup_action(input logic [15:0] code);
		logic [4:0] idx;
		idx = 5'd0;
		for (int k = 0; k < NUM_KNOWN; k++) begin
			if (KNOWN_CODES[k] == code) begin
				idx = 5'(k + 1);
			end
		end
		return idx;
	endfunction

endpackage
`default_nettype wire

### hw/rtl/cpd_front.sv
// Front end: assembles bytes into words, keeps the checksum and classifies each packet.
`default_nettype none
module cpd_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              accept,
	input  wire cpd_pkg::in_item_t item,
	output logic                   rec_push,
	output cpd_pkg::frame_rec_t    rec
);
	import cpd_pkg::*;

	logic [3:0]  pos_q;
	logic [7:0]  low_q;
	logic [15:0] sum_q;
	logic [15:0] words_q [NUM_WORDS];

	logic [15:0] word;
	logic        last_byte;

	assign word      = {item.rx_byte, low_q};
	assign last_byte = (pos_q == 4'd15);
	assign rec_push  = accept && (item.overrun || last_byte);

	always_comb begin
		rec.status = STATUS_OK;
		rec.words  = '0;
		if (item.overrun) begin
			rec.status = STATUS_OVERRUN;
		end else if (word != sum_q) begin
			rec.status = STATUS_CHECKSUM;
		end else begin
			for (int i = 0; i < NUM_WORDS; i++) begin
				rec.words[i] = words_q[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			low_q <= '0;
			sum_q <= '0;
		end else if (accept) begin
			if (item.overrun) begin
				pos_q <= '0;
				sum_q <= '0;
			end else begin
				pos_q <= pos_q + 4'd1;
				if (!pos_q[0]) begin
					low_q <= item.rx_byte;
				end else if (last_byte) begin
					sum_q <= '0;
				end else begin
					sum_q <= sum_q + word;
				end
			end
		end
	end

	// The word store needs no reset: every word is rewritten before a packet reads it.
	always_ff @(posedge clk) begin
		if (accept && !item.overrun && pos_q[0] && !last_byte) begin
			words_q[pos_q[3:1]] <= word;
		end
	end

endmodule
`default_nettype wire

### hw/rtl/cpd_queue.sv
// Small first-in first-out queue of classified packets between front end and back end.
`default_nettype none
module cpd_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire cpd_pkg::frame_rec_t push_rec,
	output logic                     full,
	input  wire logic                pop,
	output logic                     not_empty,
	output cpd_pkg::frame_rec_t      head_rec
);
	import cpd_pkg::*;

	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	frame_rec_t       mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign head_rec  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_rec;
		end
	end

endmodule
`default_nettype wire

### hw/rtl/cpd_back.sv
// Back end: decodes the command of a packet and holds the result for the receiver.
`default_nettype none
module cpd_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                rec_valid,
	input  wire cpd_pkg::frame_rec_t rec,
	output logic                     rec_take,
	output logic                     out_valid,
	output cpd_pkg::out_item_t       out_item,
	input  wire logic                out_pop
);
	import cpd_pkg::*;

	logic      out_valid_q;
	out_item_t out_q;
	out_item_t decoded;

	assign rec_take  = rec_valid && (!out_valid_q || out_pop);
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	always_comb begin
		decoded.status               = rec.status;
		decoded.header_word          = rec.words[0];
		decoded.command_code         = rec.words[1];
		decoded.action_index         = lookup_action(rec.words[1]);
		decoded.first_argument       = rec.words[6];
		decoded.second_argument_bits = {rec.words[3], rec.words[2]};
		decoded.third_argument_bits  = {rec.words[5], rec.words[4]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rec_take) begin
			out_valid_q <= 1'b1;
		end else if (out_pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rec_take) begin
			out_q <= decoded;
		end
	end

endmodule
`default_nettype wire

### hw/rtl/command_packet_deframer.sv
// Command packet deframer: serial bytes in, one checked and decoded result per packet out.
//
// Input channel: drive item and push; a transaction completes when push is high and full is
// low. Each item is one received byte, or an overrun event that drops the partial packet.
// Sixteen bytes form one packet of eight little-endian words; word 7 must equal the 16-bit
// wrapping sum of words 0 to 6.
// Result channel: while empty is low the oldest result is on result; raise pop to take it.
// One result leaves for each completed packet (accepted or checksum error) and for each
// overrun event; other bytes produce nothing.
// Throughput is one byte per clock while full is low. The byte completing a packet writes its
// record into the packet queue, and the output register loads it from the queue head once
// that register is empty or being popped, which puts the result on the result port.
// When the receiver stalls, results collect in the QUEUE_DEPTH-entry packet queue plus the
// output register; full rises only once the queue is full, and then holds every byte.
// Reset clears the byte position, the checksum, the queue and the output valid flag; no
// clearing pass is needed and items are accepted from the first cycle after reset.
`default_nettype none
module command_packet_deframer #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	output logic                    full,
	input  wire cpd_pkg::in_item_t  item,
	output logic                    empty,
	input  wire logic               pop,
	output cpd_pkg::out_item_t      result
);
	import cpd_pkg::*;

	logic       accept;
	logic       rec_push;
	frame_rec_t rec;
	logic       q_full;
	logic       q_not_empty;
	logic       q_take;
	frame_rec_t q_head;
	logic       out_valid;

	assign full   = q_full;
	assign accept = push && !q_full;
	assign empty  = !out_valid;

	cpd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.item     (item),
		.rec_push (rec_push),
		.rec      (rec)
	);

	cpd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (rec_push),
		.push_rec  (rec),
		.full      (q_full),
		.pop       (q_take),
		.not_empty (q_not_empty),
		.head_rec  (q_head)
	);

	cpd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.rec_valid (q_not_empty),
		.rec       (q_head),
		.rec_take  (q_take),
		.out_valid (out_valid),
		.out_item  (result),
		.out_pop   (pop)
	);

	// The front end must never hand a packet to a full queue.
	assert property (@(posedge clk) disable iff (!arst_n) rec_push |-> !q_full)
		else $error("packet record pushed into a full queue");

	// A waiting packet with an empty output register must show up on the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n) (q_not_empty && empty) |=> !empty)
		else $error("queued packet not moved to the output register");

	// Overrun and checksum results carry no packet contents.
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.status != STATUS_OK) |->
		(result.command_code == 16'd0 && result.action_index == 5'd0 &&
		result.header_word == 16'd0))
		else $error("error result carries packet fields");

	// An overrun event always yields a result record on the same edge.
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && item.overrun) |-> rec_push)
		else $error("overrun event produced no result");

endmodule
`default_nettype wire
